[sv/grid_budget_reach_cost_assert.svh]
// Assertion macros used by the port-level checks in gbrc_sva
`ifndef GRID_BUDGET_REACH_COST_ASSERT_SVH
`define GRID_BUDGET_REACH_COST_ASSERT_SVH

// Same-cycle implication, reset masks the check
`define GBRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define GBRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gbrc_pkg.sv]
// ----------------------------------------------------------------------------
// gbrc_pkg
// Types, constants and neighbor tables for the grid reach-cost search block.
// ----------------------------------------------------------------------------
package gbrc_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [6:0] COST_INIT = 7'd80;
    localparam logic [6:0] STEP_ORTH = 7'd5;
    localparam logic [6:0] STEP_DIAG = 7'd7;

    // Request selector on the input tuser
    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Response kind on the output tuser
    localparam logic RESP_DONE = 1'b0;
    localparam logic RESP_READ = 1'b1;

    // Register indexes on the config port
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLR,
        S_SEED,
        S_POP,
        S_RDC,
        S_CHK,
        S_NRD,
        S_NEV,
        S_DONE
    } t_state;

    // Cost map word
    typedef struct packed {
        logic       inq;
        logic       reached;
        logic [6:0] cost;
    } t_cm;

    // Controller commands
    typedef struct packed {
        logic acc;
        logic sweep;
        logic sweep_obs;
        logic seed;
        logic pop;
        logic rd_cur;
        logic chk;
        logic nb_rd;
        logic nb_ev;
        logic rd_out;
        logic done_out;
    } t_ctl;

    // Datapath status
    typedef struct packed {
        logic  take;
        t_func func;
        logic  start_skip;
        logic  sweep_last;
        logic  fifo_empty;
        logic  over;
        logic  nb_skip;
        logic  nb_last;
    } t_sts;

    // Neighbor offsets: four orthogonal first, then four diagonal
    function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0: d = 2'sd0;
            3'd1: d = -2'sd1;
            3'd2: d = 2'sd1;
            3'd3: d = 2'sd0;
            3'd4: d = -2'sd1;
            3'd5: d = 2'sd1;
            3'd6: d = -2'sd1;
            default: d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0: d = 2'sd1;
            3'd1: d = 2'sd0;
            3'd2: d = 2'sd0;
            3'd3: d = -2'sd1;
            3'd4: d = 2'sd1;
            3'd5: d = 2'sd1;
            3'd6: d = -2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

endpackage

[sv/gbrc_ctrl.sv]
// ----------------------------------------------------------------------------
// gbrc_ctrl
// Sequencer for map clearing, request handling and the worklist search.
// ----------------------------------------------------------------------------
module gbrc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gbrc_pkg::t_sts i_sts,
    output gbrc_pkg::t_ctl o_ctl
);

    gbrc_pkg::t_state r_state;
    gbrc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbrc_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            gbrc_pkg::S_INIT: begin
                o_ctl.sweep     = 1'b1;
                o_ctl.sweep_obs = 1'b1;
                if (i_sts.sweep_last) n_state = gbrc_pkg::S_IDLE;
            end
            gbrc_pkg::S_IDLE: begin
                o_ctl.acc = 1'b1;
                if (i_sts.take) begin
                    case (i_sts.func)
                        gbrc_pkg::FUNC_START: begin
                            n_state = i_sts.start_skip ? gbrc_pkg::S_DONE : gbrc_pkg::S_CLR;
                        end
                        gbrc_pkg::FUNC_READ: n_state = gbrc_pkg::S_READ;
                        default: n_state = gbrc_pkg::S_IDLE;
                    endcase
                end
            end
            gbrc_pkg::S_READ: begin
                o_ctl.rd_out = 1'b1;
                n_state      = gbrc_pkg::S_IDLE;
            end
            gbrc_pkg::S_CLR: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) n_state = gbrc_pkg::S_SEED;
            end
            gbrc_pkg::S_SEED: begin
                o_ctl.seed = 1'b1;
                n_state    = gbrc_pkg::S_POP;
            end
            gbrc_pkg::S_POP: begin
                if (i_sts.fifo_empty) begin
                    n_state = gbrc_pkg::S_DONE;
                end else begin
                    o_ctl.pop = 1'b1;
                    n_state   = gbrc_pkg::S_RDC;
                end
            end
            gbrc_pkg::S_RDC: begin
                o_ctl.rd_cur = 1'b1;
                n_state      = gbrc_pkg::S_CHK;
            end
            gbrc_pkg::S_CHK: begin
                o_ctl.chk = 1'b1;
                n_state   = i_sts.over ? gbrc_pkg::S_POP : gbrc_pkg::S_NRD;
            end
            gbrc_pkg::S_NRD: begin
                o_ctl.nb_rd = 1'b1;
                if (!i_sts.nb_skip) begin
                    n_state = gbrc_pkg::S_NEV;
                end else if (i_sts.nb_last) begin
                    n_state = gbrc_pkg::S_POP;
                end
            end
            gbrc_pkg::S_NEV: begin
                o_ctl.nb_ev = 1'b1;
                n_state     = i_sts.nb_last ? gbrc_pkg::S_POP : gbrc_pkg::S_NRD;
            end
            gbrc_pkg::S_DONE: begin
                o_ctl.done_out = 1'b1;
                n_state        = gbrc_pkg::S_IDLE;
            end
            default: n_state = gbrc_pkg::S_INIT;
        endcase
    end

endmodule

[sv/gbrc_dp.sv]
// ----------------------------------------------------------------------------
// gbrc_dp
// Maps, worklist FIFO, neighbor stepping and the output register.
// ----------------------------------------------------------------------------
module gbrc_dp #(
    parameter int MAX_WIDTH  = gbrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gbrc_pkg::DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int DW = $clog2(MAX_WIDTH + 1),
    localparam int DH = $clog2(MAX_HEIGHT + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gbrc_pkg::t_ctl i_ctl,
    output gbrc_pkg::t_sts o_sts,
    input  logic [DW-1:0]  i_w,
    input  logic [DH-1:0]  i_h,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [23:0]    i_s_tdata,
    input  logic [1:0]     i_s_tuser,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [15:0]    o_m_tdata,
    output logic [0:0]     o_m_tuser
);

    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // Input fields
    logic [5:0]      in_x, in_y;
    logic            in_blk;
    logic [7:0]      in_budget;
    logic [XW+5:0]   in_xe;
    logic [YW+5:0]   in_ye;
    logic [AW-1:0]   in_addr;
    logic            in_store;
    logic            take;

    assign in_x      = i_s_tdata[5:0];
    assign in_y      = i_s_tdata[11:6];
    assign in_blk    = i_s_tdata[12];
    assign in_budget = i_s_tdata[20:13];
    assign in_xe     = (XW + 6)'(in_x);
    assign in_ye     = (YW + 6)'(in_y);
    assign in_addr   = {in_ye[YW-1:0], in_xe[XW-1:0]};
    assign in_store  = (int'(in_x) < MAX_WIDTH) && (int'(in_y) < MAX_HEIGHT);

    assign o_s_tready = i_ctl.acc && (!o_m_tvalid || i_m_tready);
    assign take       = i_s_tvalid && o_s_tready;

    // Request and search registers
    logic [AW-1:0]   r_start;
    logic [7:0]      r_budget;
    logic            r_err;
    logic            r_rin;
    logic [AW-1:0]   r_ptr;
    logic [AW-1:0]   r_head, r_tail;
    logic [AW:0]     r_count;
    logic [XW-1:0]   r_cx;
    logic [YW-1:0]   r_cy;
    logic [6:0]      r_c;
    logic            r_diag;
    logic [2:0]      r_k;
    logic [AW-1:0]   r_n;

    // Memories and their registered read data
    gbrc_pkg::t_cm   cm_mem [DEPTH];
    logic            om_mem [DEPTH];
    logic [AW-1:0]   fm_mem [DEPTH];
    gbrc_pkg::t_cm   r_cm_q;
    logic            r_om_q;
    logic [AW-1:0]   r_fm_q;

    // Neighbor coordinates
    logic signed [XW+1:0] nb_dx_s;
    logic signed [YW+1:0] nb_dy_s;
    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic                 nb_skip;
    logic                 nb_last;
    logic [AW-1:0]        nb_addr;
    logic [6:0]           nc;
    logic                 better;

    assign nb_dx_s = (XW + 2)'(gbrc_pkg::nb_dx(r_k));
    assign nb_dy_s = (YW + 2)'(gbrc_pkg::nb_dy(r_k));
    assign nx      = $signed({2'b00, r_cx}) + nb_dx_s;
    assign ny      = $signed({2'b00, r_cy}) + nb_dy_s;
    assign nb_skip = nx[XW+1] || ny[YW+1]
                   || ({1'b0, nx[XW:0]} >= (XW + 2)'(i_w))
                   || ({1'b0, ny[YW:0]} >= (YW + 2)'(i_h));
    assign nb_addr = {ny[YW-1:0], nx[XW-1:0]};
    assign nb_last = (r_k == (r_diag ? 3'd7 : 3'd3));
    assign nc      = r_c + ((r_k < 3'd4) ? gbrc_pkg::STEP_ORTH : gbrc_pkg::STEP_DIAG);
    assign better  = !r_om_q && (r_cm_q.cost > nc);

    // Status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.take       = take;
        o_sts.func       = gbrc_pkg::t_func'(i_s_tuser);
        o_sts.start_skip = (7'(in_x) >= 7'(i_w)) || (7'(in_y) >= 7'(i_h))
                         || (in_budget == 8'd0);
        o_sts.sweep_last = (r_ptr == AW'(DEPTH - 1));
        o_sts.fifo_empty = (r_count == '0);
        o_sts.over       = (9'(r_cm_q.cost) + 9'(gbrc_pkg::STEP_ORTH)) > 9'(r_budget);
        o_sts.nb_skip    = nb_skip;
        o_sts.nb_last    = nb_last;
    end

    // Cost map port selection
    logic            cm_we;
    logic [AW-1:0]   cm_wa, cm_ra;
    gbrc_pkg::t_cm   cm_wd;

    always_comb begin
        cm_we = 1'b0;
        cm_wa = r_ptr;
        cm_wd = '{inq: 1'b0, reached: 1'b0, cost: gbrc_pkg::COST_INIT};
        if (i_ctl.sweep) begin
            cm_we = 1'b1;
        end else if (i_ctl.seed) begin
            cm_we = 1'b1;
            cm_wa = r_start;
            cm_wd = '{inq: 1'b1, reached: 1'b1, cost: 7'd0};
        end else if (i_ctl.chk) begin
            cm_we = 1'b1;
            cm_wa = {r_cy, r_cx};
            cm_wd = '{inq: 1'b0, reached: r_cm_q.reached, cost: r_cm_q.cost};
        end else if (i_ctl.nb_ev && better) begin
            cm_we = 1'b1;
            cm_wa = r_n;
            cm_wd = '{inq: 1'b1, reached: 1'b1, cost: nc};
        end
        if (i_ctl.rd_cur) begin
            cm_ra = r_fm_q;
        end else if (i_ctl.nb_rd) begin
            cm_ra = nb_addr;
        end else begin
            cm_ra = in_addr;
        end
    end

    // Cost map
    always_ff @(posedge i_clk) begin
        if (cm_we) cm_mem[cm_wa] <= cm_wd;
        r_cm_q <= cm_mem[cm_ra];
    end

    // Obstacle map
    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_obs) begin
            om_mem[r_ptr] <= 1'b0;
        end else if (take && o_sts.func == gbrc_pkg::FUNC_LOAD && in_store) begin
            om_mem[in_addr] <= in_blk;
        end
        r_om_q <= om_mem[nb_addr];
    end

    // Worklist FIFO storage
    logic            push;
    logic [AW-1:0]   push_d;

    assign push   = i_ctl.seed || (i_ctl.nb_ev && better && !r_cm_q.inq);
    assign push_d = i_ctl.seed ? r_start : r_n;

    always_ff @(posedge i_clk) begin
        if (push) fm_mem[i_ctl.seed ? '0 : r_tail] <= push_d;
        r_fm_q <= fm_mem[r_head];
    end

    // Control registers of the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            if (i_ctl.sweep) r_ptr <= r_ptr + 1'b1;
            if (i_ctl.seed) begin
                r_head  <= '0;
                r_tail  <= AW'(1);
                r_count <= (AW + 1)'(1);
            end else if (i_ctl.pop) begin
                r_head  <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (push) begin
                r_tail  <= r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_ctl.chk) begin
                r_k <= '0;
            end else if ((i_ctl.nb_rd && nb_skip) || i_ctl.nb_ev) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Payload registers of the request and current cell
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_start  <= in_addr;
            r_budget <= in_budget;
            r_err    <= (7'(in_x) >= 7'(i_w)) || (7'(in_y) >= 7'(i_h));
            r_rin    <= in_store;
        end
        if (i_ctl.rd_cur) begin
            r_cx <= r_fm_q[XW-1:0];
            r_cy <= r_fm_q[AW-1:XW];
        end
        if (i_ctl.chk) begin
            r_c    <= r_cm_q.cost;
            r_diag <= (9'(r_cm_q.cost) + 9'(gbrc_pkg::STEP_DIAG)) <= 9'(r_budget);
        end
        if (i_ctl.nb_rd) r_n <= nb_addr;
    end

    // Output register
    logic            r_ovalid;
    logic            r_okind;
    logic [6:0]      r_ocost;
    logic            r_oreach;
    logic            r_oerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.rd_out || i_ctl.done_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_out) begin
            r_okind  <= gbrc_pkg::RESP_READ;
            r_ocost  <= r_rin ? r_cm_q.cost : gbrc_pkg::COST_INIT;
            r_oreach <= r_rin && r_cm_q.reached;
            r_oerr   <= 1'b0;
        end else if (i_ctl.done_out) begin
            r_okind  <= gbrc_pkg::RESP_DONE;
            r_ocost  <= 7'd0;
            r_oreach <= 1'b0;
            r_oerr   <= r_err;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_oerr, r_oreach, r_ocost};
    assign o_m_tuser  = r_okind;

endmodule

[sv/grid_budget_reach_cost.sv]
// ----------------------------------------------------------------------------
// grid_budget_reach_cost
// Reachable-cost search over a loaded obstacle grid, 5/7 step costs.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects load, start or read. A load writes one
// obstacle cell, with no response. A read returns the cell's cost and reached
// flag. A start whose cell lies in the grid and whose budget is nonzero clears
// every cell of the cost map (4096 at the default size), then runs the
// worklist search: each popped cell is read and checked, then its neighbors
// are read and evaluated in turn through one cost-map port. The input is
// stalled until a search finishes, then a single finish response is sent.
// Output stream (m_axis): one register; a request is taken only while that
// register is empty or being read out, so a stalled receiver holds the
// response and stalls the input at once.
// Reset: a clearing pass runs over every cell of the obstacle and cost maps,
// 4096 at the default size; no request is taken meanwhile, the APB port works.
// Config (APB): grid_width at 0x0, grid_height at 0x4.
// ----------------------------------------------------------------------------
module grid_budget_reach_cost #(
    parameter int MAX_WIDTH  = gbrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gbrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cell_x, cell_y, blocked, budget, pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cell_cost, reached, start_error, pad
    output logic [0:0]  m_axis_tuser,   // resp_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int DH = $clog2(MAX_HEIGHT + 1);

    logic [6:0]     r_grid_width;
    logic [6:0]     r_grid_height;
    logic [DW-1:0]  w_use;
    logic [DH-1:0]  h_use;
    gbrc_pkg::t_ctl ctl;
    gbrc_pkg::t_sts sts;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == gbrc_pkg::REG_HEIGHT) begin
                r_grid_height <= pwdata[6:0];
            end else begin
                r_grid_width <= pwdata[6:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == gbrc_pkg::REG_HEIGHT) ? 32'(r_grid_height)
                                                        : 32'(r_grid_width);

    // Clamp dimensions to 1..max
    always_comb begin
        if (r_grid_width == 7'd0) begin
            w_use = DW'(1);
        end else if (int'(r_grid_width) > MAX_WIDTH) begin
            w_use = DW'(MAX_WIDTH);
        end else begin
            w_use = DW'(r_grid_width);
        end
        if (r_grid_height == 7'd0) begin
            h_use = DH'(1);
        end else if (int'(r_grid_height) > MAX_HEIGHT) begin
            h_use = DH'(MAX_HEIGHT);
        end else begin
            h_use = DH'(r_grid_height);
        end
    end

    gbrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    gbrc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_w        (w_use),
        .i_h        (h_use),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

[sv/gbrc_sva.sv]
// ----------------------------------------------------------------------------
// gbrc_sva
// Port-level checks for grid_budget_reach_cost, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_budget_reach_cost_assert.svh"

module gbrc_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // Response held while stalled
    `GBRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "response dropped while stalled")

    // A start transaction stalls the input on the next cycle
    `GBRC_ASSERT_NEXT(a_start_stall, s_axis_tvalid && s_axis_tready && s_axis_tuser == gbrc_pkg::FUNC_START, !s_axis_tready, "input not stalled after start")

    // Read answer: no start error, cost within range
    `GBRC_ASSERT_NOW(a_read_fields, m_axis_tvalid && m_axis_tuser[0] == gbrc_pkg::RESP_READ, !m_axis_tdata[8] && m_axis_tdata[6:0] <= gbrc_pkg::COST_INIT, "bad read answer fields")

    // Finish response: cost and reached are zero
    `GBRC_ASSERT_NOW(a_done_fields, m_axis_tvalid && m_axis_tuser[0] == gbrc_pkg::RESP_DONE, m_axis_tdata[7:0] == 8'd0, "bad finish fields")

    // Unreached read cell reports the initial cost
    `GBRC_ASSERT_NOW(a_unreached_cost, m_axis_tvalid && m_axis_tuser[0] == gbrc_pkg::RESP_READ && !m_axis_tdata[7], m_axis_tdata[6:0] == gbrc_pkg::COST_INIT, "unreached cell cost mismatch")

endmodule

bind grid_budget_reach_cost gbrc_sva u_gbrc_sva (.*);

[tb/grid_budget_reach_cost_checker.sv]
// ----------------------------------------------------------------------------
// grid_budget_reach_cost_checker
// Watches the request, response and APB channels of the reach-cost block. It
// keeps its own obstacle, cost and reached maps, runs the budgeted 5/7 search
// on every accepted start that lies in the grid with a nonzero budget, and
// compares each response with the oldest expected one.
// ----------------------------------------------------------------------------
module grid_budget_reach_cost_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cell_x, cell_y, blocked, budget, pad
    input  logic [1:0]  s_axis_tuser,   // func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // cell_cost, reached, start_error, pad
    input  logic [0:0]  m_axis_tuser,   // resp_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = 4096;

    typedef struct packed {
        logic       kind;
        logic [6:0] cost;
        logic       reached;
        logic       start_error;
    } t_resp;

    // Model state
    logic       obst_map [CELLS];
    logic [6:0] cost_map [CELLS];
    logic       reach_map [CELLS];
    logic [6:0] cols_reg;
    logic [6:0] rows_reg;
    t_resp      resp_q [$];

    function automatic int clamp_dim(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > 64) return 64;
        return int'(v);
    endfunction

    // Budgeted label-correcting search, FIFO worklist with in-queue flags
    function automatic void run_reach(input int sx, input int sy, input int budget,
                                      input int w, input int h);
        int   work [$];
        logic inq [CELLS];
        int   idx, c, px, py, lim, nx, ny, n, nc;
        int   dx [8] = '{0, -1, 1, 0, -1, 1, -1, 1};
        int   dy [8] = '{1, 0, 0, -1, 1, 1, -1, -1};
        for (int i = 0; i < CELLS; i++) begin
            cost_map[i]  = gbrc_pkg::COST_INIT;
            reach_map[i] = 1'b0;
            inq[i]       = 1'b0;
        end
        idx = sy * 64 + sx;
        cost_map[idx]  = 7'd0;
        reach_map[idx] = 1'b1;
        work.push_back(idx);
        inq[idx] = 1'b1;
        while (work.size() > 0) begin
            idx = work.pop_front();
            inq[idx] = 1'b0;
            c  = int'(cost_map[idx]);
            px = idx % 64;
            py = idx / 64;
            if (c + 5 > budget) continue;
            lim = (c + 7 <= budget) ? 8 : 4;
            for (int k = 0; k < lim; k++) begin
                nx = px + dx[k];
                ny = py + dy[k];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                n = ny * 64 + nx;
                if (obst_map[n]) continue;
                nc = c + ((k < 4) ? 5 : 7);
                if (int'(cost_map[n]) > nc) begin
                    cost_map[n]  = nc[6:0];
                    reach_map[n] = 1'b1;
                    if (!inq[n]) begin
                        work.push_back(n);
                        inq[n] = 1'b1;
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = resp_q.size();

    // Model update on each accepted transaction
    always @(posedge i_clk) begin
        logic [5:0]      cx, cy;
        gbrc_pkg::t_func fn;
        t_resp           exp_r, got_r;
        int              w, h;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                obst_map[i]  = 1'b0;
                cost_map[i]  = gbrc_pkg::COST_INIT;
                reach_map[i] = 1'b0;
            end
            cols_reg = 7'd64;
            rows_reg = 7'd64;
            resp_q.delete();
            o_fail_count = 0;
        end else begin
            // Register writes
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == gbrc_pkg::REG_WIDTH) cols_reg = pwdata[6:0];
                else                                 rows_reg = pwdata[6:0];
            end
            // Response check
            if (m_axis_tvalid && m_axis_tready) begin
                got_r.kind        = m_axis_tuser[0];
                got_r.cost        = m_axis_tdata[6:0];
                got_r.reached     = m_axis_tdata[7];
                got_r.start_error = m_axis_tdata[8];
                if (resp_q.size() == 0) begin
                    report_mismatch("unexpected response kind", got_r.kind, -1);
                end else begin
                    exp_r = resp_q.pop_front();
                    if (got_r.kind != exp_r.kind)
                        report_mismatch("resp_kind", got_r.kind, exp_r.kind);
                    if (got_r.cost != exp_r.cost)
                        report_mismatch("cell_cost", got_r.cost, exp_r.cost);
                    if (got_r.reached != exp_r.reached)
                        report_mismatch("reached", got_r.reached, exp_r.reached);
                    if (got_r.start_error != exp_r.start_error)
                        report_mismatch("start_error", got_r.start_error, exp_r.start_error);
                end
            end
            // Request prediction
            if (s_axis_tvalid && s_axis_tready) begin
                cx = s_axis_tdata[5:0];
                cy = s_axis_tdata[11:6];
                fn = gbrc_pkg::t_func'(s_axis_tuser);
                w  = clamp_dim(cols_reg);
                h  = clamp_dim(rows_reg);
                case (fn)
                    gbrc_pkg::FUNC_LOAD: begin
                        obst_map[int'(cy) * 64 + int'(cx)] = s_axis_tdata[12];
                    end
                    gbrc_pkg::FUNC_START: begin
                        exp_r = '0;
                        exp_r.kind = gbrc_pkg::RESP_DONE;
                        if (int'(cx) >= w || int'(cy) >= h)
                            exp_r.start_error = 1'b1;
                        else if (s_axis_tdata[20:13] != 0)
                            run_reach(cx, cy, int'(s_axis_tdata[20:13]), w, h);
                        resp_q.push_back(exp_r);
                    end
                    gbrc_pkg::FUNC_READ: begin
                        exp_r = '0;
                        exp_r.kind    = gbrc_pkg::RESP_READ;
                        exp_r.cost    = cost_map[int'(cy) * 64 + int'(cx)];
                        exp_r.reached = reach_map[int'(cy) * 64 + int'(cx)];
                        resp_q.push_back(exp_r);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the reach-cost block: obstacle loads, searches and reads over
// several grid sizes set through APB, with bursty requests and a stalling
// receiver. The checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data = '0;   // cell_x, cell_y, blocked, budget, pad
    logic [1:0]  s_user = '0;   // func
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;        // cell_cost, reached, start_error, pad
    logic [0:0]  m_user;        // resp_kind
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int          focus_x = 0;
    int          focus_y = 0;

    always #5 i_clk = ~i_clk;

    grid_budget_reach_cost u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    grid_budget_reach_cost_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Timeout
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls: alternating always-ready and random-stall windows
    always @(posedge i_clk) begin
        if ((cycle_cnt / 300) % 3 == 0) m_ready <= 1'b1;
        else                             m_ready <= ($urandom_range(0, 99) < 60);
    end

    // One request transaction; valid stays high within a burst
    task automatic send_req(input gbrc_pkg::t_func fn, input int x, input int y,
                            input logic blk, input int budget);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= {3'b000, budget[7:0], blk, y[5:0], x[5:0]};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        burst_left--;
    endtask

    // Drain, then let the block settle before touching registers
    task automatic wait_idle();
        if (s_valid) s_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input int cols, input int rows);
        wait_idle();
        apb_write(gbrc_pkg::REG_WIDTH, cols);
        apb_write(gbrc_pkg::REG_HEIGHT, rows);
    endtask

    // Random traffic: mostly loads and reads around a recent start cell
    task automatic random_phase(input int n_items, input int span);
        int r, x, y;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 8) begin
                x = focus_x + $urandom_range(0, 20) - 10;
                y = focus_y + $urandom_range(0, 20) - 10;
                x = (x < 0) ? 0 : ((x > span) ? span : x);
                y = (y < 0) ? 0 : ((y > span) ? span : y);
            end else begin
                x = $urandom_range(0, 63);
                y = $urandom_range(0, 63);
            end
            if (r < 5) begin
                focus_x = x;
                focus_y = y;
                send_req(gbrc_pkg::FUNC_START, x, y, 1'b0,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(5, 90));
            end else if (r < 7) begin
                send_req(gbrc_pkg::FUNC_NONE, x, y, $urandom_range(0, 1),
                         $urandom_range(0, 255));
            end else if (r < 40) begin
                send_req(gbrc_pkg::FUNC_LOAD, x, y, ($urandom_range(0, 2) == 0),
                         $urandom_range(0, 255));
            end else begin
                send_req(gbrc_pkg::FUNC_READ, x, y, $urandom_range(0, 1),
                         $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default 64x64 grid
        send_req(gbrc_pkg::FUNC_LOAD, 0, 0, 1'b1, 0);
        send_req(gbrc_pkg::FUNC_LOAD, 63, 63, 1'b1, 255);
        send_req(gbrc_pkg::FUNC_LOAD, 1, 0, 1'b1, 0);
        send_req(gbrc_pkg::FUNC_START, 0, 0, 1'b0, 255);    // blocked start still searches
        send_req(gbrc_pkg::FUNC_READ, 0, 0, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 1, 1, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 1, 0, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 0, 5, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 63, 63, 1'b1, 255);
        send_req(gbrc_pkg::FUNC_START, 63, 0, 1'b1, 6);     // orthogonal only
        send_req(gbrc_pkg::FUNC_READ, 62, 1, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 63, 1, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_START, 63, 0, 1'b0, 7);     // diagonals just fit
        send_req(gbrc_pkg::FUNC_READ, 62, 1, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_START, 10, 10, 1'b0, 0);    // zero budget keeps maps
        send_req(gbrc_pkg::FUNC_READ, 62, 1, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_NONE, 63, 63, 1'b1, 255);
        send_req(gbrc_pkg::FUNC_LOAD, 40, 40, 1'b0, 0);

        // Small grid: start outside the grid, load outside it kept
        set_grid(8, 8);
        send_req(gbrc_pkg::FUNC_START, 10, 2, 1'b0, 50);
        send_req(gbrc_pkg::FUNC_START, 2, 8, 1'b0, 50);
        send_req(gbrc_pkg::FUNC_LOAD, 20, 20, 1'b1, 0);
        send_req(gbrc_pkg::FUNC_START, 7, 7, 1'b0, 255);
        send_req(gbrc_pkg::FUNC_READ, 0, 0, 1'b0, 0);
        send_req(gbrc_pkg::FUNC_READ, 8, 7, 1'b0, 0);
        focus_x = 4; focus_y = 4;
        random_phase(80, 9);

        // Zero counts as one
        set_grid(0, 0);
        send_req(gbrc_pkg::FUNC_START, 0, 0, 1'b0, 255);
        send_req(gbrc_pkg::FUNC_START, 1, 0, 1'b0, 255);
        random_phase(30, 3);

        // Above the store counts as the maximum
        set_grid(127, 127);
        send_req(gbrc_pkg::FUNC_READ, 20, 20, 1'b0, 0);
        focus_x = 30; focus_y = 30;
        random_phase(120, 63);

        set_grid(64, 1);
        focus_x = 32; focus_y = 0;
        random_phase(60, 63);

        set_grid($urandom_range(2, 20), $urandom_range(2, 20));
        focus_x = 5; focus_y = 5;
        random_phase(140, 20);

        set_grid(64, 64);
        focus_x = 60; focus_y = 60;
        random_phase(150, 63);

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[grid_budget_reach_cost.f]
+incdir+sv
sv/gbrc_pkg.sv
sv/gbrc_ctrl.sv
sv/gbrc_dp.sv
sv/grid_budget_reach_cost.sv
sv/gbrc_sva.sv
tb/grid_budget_reach_cost_checker.sv
tb/testbench.sv
